### hw/rtl/nbfw_pkg.sv
// ----------------------------------------------------------------------------
// nbfw_pkg
// Types and constants shared by the nested block frame writer.
// ----------------------------------------------------------------------------
package nbfw_pkg;

  localparam int ADDR_BITS_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int WADDR_W  = 16;
  localparam int FILL_W   = 17;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 2;

  localparam int LEN_BYTES = 4;

  localparam logic [FILL_W-1:0] BUFFER_SIZE_RST = 17'd65536;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BUF_FULL   = 2'd1,
    ST_STACK_FULL = 2'd2,
    ST_NO_BLOCK   = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

### hw/rtl/nbfw_if.sv
// ----------------------------------------------------------------------------
// nbfw_if
// Valid/ready channels of the nested block frame writer.
// ----------------------------------------------------------------------------
interface nbfw_in_if;
  logic                           valid;
  logic                           ready;
  logic [nbfw_pkg::ACTION_W-1:0]  action;
  logic [nbfw_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface nbfw_out_if;
  logic                           valid;
  logic                           ready;
  logic                           write_enable;
  logic [nbfw_pkg::WADDR_W-1:0]   write_address;
  logic [nbfw_pkg::BYTE_W-1:0]    write_byte;
  logic                           last;
  logic [nbfw_pkg::STATUS_W-1:0]  status;
  logic [nbfw_pkg::FILL_W-1:0]    bytes_used;

  modport source (output valid, write_enable, write_address, write_byte, last, status,
                  bytes_used, input ready);
  modport sink   (input valid, write_enable, write_address, write_byte, last, status,
                  bytes_used, output ready);
endinterface

interface nbfw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nbfw_pkg::FILL_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/nbfw_stack.sv
// ----------------------------------------------------------------------------
// nbfw_stack
// Offset stack: top entry in a register, the entries below it in a memory.
// ----------------------------------------------------------------------------
module nbfw_stack #(
  parameter int STACK_DEPTH = nbfw_pkg::STACK_DEPTH_DEF,
  parameter int ENTRY_BITS  = nbfw_pkg::FILL_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nbfw_pkg::stack_ctl_t               ctl,
  input  logic [ENTRY_BITS-1:0]              push_data,
  output logic [ENTRY_BITS-1:0]              top,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count
);

  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int IDX_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [ENTRY_BITS-1:0] mem [STACK_DEPTH];
  logic [ENTRY_BITS-1:0] top_r;
  logic [ENTRY_BITS-1:0] rd_r;
  logic [CNT_BITS-1:0]   count_r;
  logic                  refill_r;
  logic [CNT_BITS-1:0]   below_top;
  logic [CNT_BITS-1:0]   below_next;

  assign below_top  = count_r - CNT_BITS'(1);
  assign below_next = count_r - CNT_BITS'(2);
  assign top        = top_r;
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      refill_r <= 1'b0;
    end else begin
      refill_r <= ctl.pop;
      if (ctl.push) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (ctl.pop) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

  // Spill the old top into memory on push; on pop, read the entry below into rd_r, which then refills the top.
  always_ff @(posedge clk) begin
    if (ctl.push && (count_r != '0)) begin
      mem[below_top[IDX_BITS-1:0]] <= top_r;
    end
    if (ctl.pop) begin
      rd_r <= mem[below_next[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top_r <= push_data;
    end else if (refill_r) begin
      top_r <= rd_r;
    end
  end

endmodule

### hw/rtl/nested_block_frame_writer_unit.sv
// ----------------------------------------------------------------------------
// nested_block_frame_writer_unit
// Writes data bytes and backfilled 32-bit big-endian block lengths.
// ----------------------------------------------------------------------------
// Results are registered: an accepted request loads the output register.
// Throughput: one request per cycle for data bytes and block starts while the
// output is not stalled; an end block emits four write results in turn and
// holds off input until the last of them is loaded into the output register.
// Reset: fill position and stack count clear, buffer size returns to 65536;
// the offset stack memory is not cleared.
module nested_block_frame_writer_unit #(
  parameter int ADDR_BITS   = nbfw_pkg::ADDR_BITS_DEF,
  parameter int STACK_DEPTH = nbfw_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  nbfw_in_if.sink      in_ch,
  nbfw_out_if.source   out_ch,
  nbfw_cfg_if.sink     cfg_ch
);

  localparam int FILL_W   = nbfw_pkg::FILL_W;
  localparam int LEN_W    = nbfw_pkg::LEN_W;
  localparam int BYTE_W   = nbfw_pkg::BYTE_W;
  localparam int WADDR_W  = nbfw_pkg::WADDR_W;
  localparam int OFS_BITS = (ADDR_BITS < FILL_W) ? ADDR_BITS : FILL_W;
  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int CAP_W    = FILL_W + 1;
  localparam logic [CAP_W-1:0] SPACE =
    CAP_W'(64'd1 << ((ADDR_BITS < FILL_W) ? ADDR_BITS : FILL_W));

  logic [FILL_W-1:0]   bs_r;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic                busy_r;
  logic                busy_nxt;
  logic [1:0]          beat_r;
  logic [1:0]          beat_nxt;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    len_nxt;
  logic [OFS_BITS-1:0] ofs_r;

  logic                out_valid_r;
  logic                we_r,   we_nxt;
  logic [WADDR_W-1:0]  addr_r, addr_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                last_r, last_nxt;
  nbfw_pkg::status_t   st_r,   st_nxt;

  nbfw_pkg::stack_ctl_t sctl;
  logic [OFS_BITS-1:0]  stk_top;
  logic [CNT_BITS-1:0]  stk_count;

  logic                 slot_free;
  logic                 in_acc;
  logic                 beat_load;
  logic [CAP_W-1:0]     bs_ext;
  logic [CAP_W-1:0]     cap;
  logic [CAP_W-1:0]     fill_plus1;
  logic [CAP_W-1:0]     fill_plus4;
  logic [LEN_W-1:0]     body_len;
  logic [OFS_BITS-1:0]  beat_ofs;
  logic [OFS_BITS+WADDR_W-1:0] top_wide;
  logic [OFS_BITS+WADDR_W-1:0] beat_wide;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !busy_r && slot_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign beat_load   = busy_r && slot_free;
  assign cfg_ch.ready = 1'b1;

  assign bs_ext     = {1'b0, bs_r};
  assign cap        = (bs_ext > SPACE) ? SPACE : bs_ext;
  assign fill_plus1 = {1'b0, fill_r} + CAP_W'(1);
  assign fill_plus4 = {1'b0, fill_r} + CAP_W'(nbfw_pkg::LEN_BYTES);
  assign body_len   = LEN_W'(fill_r) - LEN_W'(stk_top) - LEN_W'(nbfw_pkg::LEN_BYTES);
  assign beat_ofs   = ofs_r + OFS_BITS'(beat_r);
  assign top_wide   = {{WADDR_W{1'b0}}, stk_top};
  assign beat_wide  = {{WADDR_W{1'b0}}, beat_ofs};

  nbfw_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ENTRY_BITS  (OFS_BITS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .push_data (fill_r[OFS_BITS-1:0]),
    .top       (stk_top),
    .count     (stk_count)
  );

  always_comb begin
    fill_nxt  = fill_r;
    busy_nxt  = busy_r;
    beat_nxt  = beat_r;
    len_nxt   = len_r;
    sctl      = '0;
    we_nxt    = 1'b0;
    addr_nxt  = '0;
    byte_nxt  = '0;
    last_nxt  = 1'b1;
    st_nxt    = nbfw_pkg::ST_OK;

    if (beat_load) begin
      // advance the backfill: one length byte per result, MSB first
      we_nxt   = 1'b1;
      addr_nxt = beat_wide[WADDR_W-1:0];
      last_nxt = (beat_r == 2'd3);
      beat_nxt = beat_r + 2'd1;
      busy_nxt = (beat_r != 2'd3);
      case (beat_r)
        2'd1:    byte_nxt = len_r[23:16];
        2'd2:    byte_nxt = len_r[15:8];
        default: byte_nxt = len_r[7:0];
      endcase
    end else if (in_acc) begin
      case (nbfw_pkg::action_t'(in_ch.action))
        nbfw_pkg::ACT_WRITE: begin
          if (fill_plus1 > cap) begin
            st_nxt = nbfw_pkg::ST_BUF_FULL;
          end else begin
            we_nxt   = 1'b1;
            addr_nxt = fill_r[WADDR_W-1:0];
            byte_nxt = in_ch.data_byte;
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        nbfw_pkg::ACT_START: begin
          if (fill_plus4 > cap) begin
            st_nxt = nbfw_pkg::ST_BUF_FULL;
          end else if (stk_count == CNT_BITS'(STACK_DEPTH)) begin
            st_nxt = nbfw_pkg::ST_STACK_FULL;
          end else begin
            sctl.push = 1'b1;
            fill_nxt  = fill_r + FILL_W'(nbfw_pkg::LEN_BYTES);
          end
        end
        nbfw_pkg::ACT_END: begin
          if (stk_count == '0) begin
            st_nxt = nbfw_pkg::ST_NO_BLOCK;
          end else begin
            sctl.pop = 1'b1;
            we_nxt   = 1'b1;
            addr_nxt = top_wide[WADDR_W-1:0];
            byte_nxt = body_len[31:24];
            last_nxt = 1'b0;
            len_nxt  = body_len;
            busy_nxt = 1'b1;
            beat_nxt = 2'd1;
          end
        end
        default: begin
          // unused action code: drop it with an ok result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= nbfw_pkg::BUFFER_SIZE_RST;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        bs_r <= cfg_ch.data;
      end
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      beat_r <= beat_nxt;
      if (in_acc || beat_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    if (in_acc) begin
      ofs_r <= stk_top;
    end
    if (in_acc || beat_load) begin
      we_r   <= we_nxt;
      addr_r <= addr_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_enable  = we_r;
  assign out_ch.write_address = addr_r;
  assign out_ch.write_byte    = byte_r;
  assign out_ch.last          = last_r;
  assign out_ch.status        = st_r;
  assign out_ch.bytes_used    = fill_r;

endmodule

### test/nbfw_checker.sv
// ----------------------------------------------------------------------------
// nbfw_checker
// Watches the request, result and buffer-size channels of the frame writer,
// keeps its own fill position, block stack and capacity, predicts the byte
// writes and status of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module nbfw_checker (
  input  logic clk,
  input  logic rst_n,
  nbfw_in_if   in_ch,
  nbfw_out_if  out_ch,
  nbfw_cfg_if  cfg_ch,
  output int   err_count,
  output int   pending,
  output int   fill_level,
  output int   open_blocks,
  output int   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACTION_W    = nbfw_pkg::ACTION_W;
  localparam int BYTE_W      = nbfw_pkg::BYTE_W;
  localparam int WADDR_W     = nbfw_pkg::WADDR_W;
  localparam int FILL_W      = nbfw_pkg::FILL_W;
  localparam int LEN_W       = nbfw_pkg::LEN_W;
  localparam int LEN_BYTES   = nbfw_pkg::LEN_BYTES;
  localparam int STACK_DEPTH = nbfw_pkg::STACK_DEPTH_DEF;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  wbyte;
    logic               last;
    nbfw_pkg::status_t  st;
    logic [FILL_W-1:0]  used;
  } wr_result_t;

  logic [FILL_W-1:0]  buf_size;
  logic [FILL_W-1:0]  fill;
  logic [WADDR_W-1:0] offsets [STACK_DEPTH];
  int                 depth;
  int                 nerr = 0;
  int                 nres = 0;
  wr_result_t         writes_due [$];

  task automatic add_write(input logic we, input logic [WADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] wbyte, input logic last,
                           input nbfw_pkg::status_t st);
    wr_result_t r;
    r.we = we;
    r.addr = addr;
    r.wbyte = wbyte;
    r.last = last;
    r.st = st;
    r.used = fill;
    writes_due = {writes_due, r};
  endtask

  task automatic predict_request(input logic [ACTION_W-1:0] act,
                                 input logic [BYTE_W-1:0] d);
    longint             cap;
    longint             space;
    logic [WADDR_W-1:0] base;
    logic [LEN_W-1:0]   blen;
    space = longint'(1) << nbfw_pkg::ADDR_BITS_DEF;
    cap = (longint'(buf_size) < space) ? longint'(buf_size) : space;
    case (act)
      nbfw_pkg::ACT_WRITE: begin
        if (longint'(fill) + 1 > cap) begin
          add_write(1'b0, '0, '0, 1'b1, nbfw_pkg::ST_BUF_FULL);
        end else begin
          base = fill[WADDR_W-1:0];
          fill = fill + 1'b1;
          add_write(1'b1, base, d, 1'b1, nbfw_pkg::ST_OK);
        end
      end
      nbfw_pkg::ACT_START: begin
        // room is tested before the stack
        if (longint'(fill) + LEN_BYTES > cap) begin
          add_write(1'b0, '0, '0, 1'b1, nbfw_pkg::ST_BUF_FULL);
        end else if (depth >= STACK_DEPTH) begin
          add_write(1'b0, '0, '0, 1'b1, nbfw_pkg::ST_STACK_FULL);
        end else begin
          offsets[depth] = fill[WADDR_W-1:0];
          depth++;
          fill = fill + FILL_W'(LEN_BYTES);
          add_write(1'b0, '0, '0, 1'b1, nbfw_pkg::ST_OK);
        end
      end
      nbfw_pkg::ACT_END: begin
        if (depth == 0) begin
          add_write(1'b0, '0, '0, 1'b1, nbfw_pkg::ST_NO_BLOCK);
        end else begin
          depth--;
          base = offsets[depth];
          blen = LEN_W'(fill) - LEN_W'(base) - LEN_W'(LEN_BYTES);
          // backfill the length, most significant byte first
          for (int k = 0; k < LEN_BYTES; k++) begin
            add_write(1'b1, WADDR_W'(base + k), blen[LEN_W-1-8*k -: 8],
                      k == LEN_BYTES - 1, nbfw_pkg::ST_OK);
          end
        end
      end
      default: add_write(1'b0, '0, '0, 1'b1, nbfw_pkg::ST_OK);
    endcase
  endtask

  function automatic int field_bad(input string name, input longint e, input longint a);
    if (e == a) return 0;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, a);
    return 1;
  endfunction

  always @(posedge clk) begin
    wr_result_t e;
    int         bad;
    if (!rst_n) begin
      writes_due.delete();
      buf_size = nbfw_pkg::BUFFER_SIZE_RST;
      fill = '0;
      depth = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        nres++;
        if (writes_due.size() == 0) begin
          $display("%0t: result with none expected: we %0h addr %0h byte %0h status %0h",
                   $time, out_ch.write_enable, out_ch.write_address, out_ch.write_byte,
                   out_ch.status);
          nerr++;
        end else begin
          e = writes_due.pop_front();
          bad = 0;
          bad += field_bad("write_enable", e.we, out_ch.write_enable);
          bad += field_bad("write_address", e.addr, out_ch.write_address);
          bad += field_bad("write_byte", e.wbyte, out_ch.write_byte);
          bad += field_bad("last", e.last, out_ch.last);
          bad += field_bad("status", longint'(e.st), out_ch.status);
          bad += field_bad("bytes_used", e.used, out_ch.bytes_used);
          if (bad != 0) nerr++;
        end
      end
      // a request at this edge still sees the old buffer size
      if (in_ch.valid && in_ch.ready) predict_request(in_ch.action, in_ch.data_byte);
      if (cfg_ch.valid && cfg_ch.ready) buf_size = cfg_ch.data;
    end
    err_count    <= nerr;
    pending      <= writes_due.size();
    fill_level   <= int'(fill);
    open_blocks  <= depth;
    results_seen <= nres;
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the frame writer with directed and random data, start and end
// requests over several buffer sizes, with random idling on both channels,
// one long output stall and a full-rate run at the capacity edge.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACTION_W = nbfw_pkg::ACTION_W;
  localparam int BYTE_W   = nbfw_pkg::BYTE_W;
  localparam int FILL_W   = nbfw_pkg::FILL_W;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;

  nbfw_in_if  in_ch ();
  nbfw_out_if out_ch ();
  nbfw_cfg_if cfg_ch ();

  int err_count;
  int pending;
  int fill_level;
  int open_blocks;
  int results_seen;
  int items_sent;
  int calm [2];
  bit fast_mode;
  bit hold_req;
  bit hold_taken;

  nested_block_frame_writer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  nbfw_checker frame_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .err_count    (err_count),
    .pending      (pending),
    .fill_level   (fill_level),
    .open_blocks  (open_blocks),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("[nested_block_frame_writer_unit] ERROR");
    $finish;
  end

  // side 0 is the request sender, side 1 the result receiver
  function automatic int draw_gap(input int side);
    if (fast_mode) return 0;
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    if ($urandom_range(7, 0) == 0) begin
      calm[side] = $urandom_range(30, 8);
      return 0;
    end
    return $urandom_range(6, 0);
  endfunction

  task automatic send_req(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // drop valid and wait until every predicted write has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input int size);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= FILL_W'(size);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_mix(input int n, input int w_start, input int w_end);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if (r < 3) send_req(ACT_UNUSED, BYTE_W'($urandom));
      else if (r < 3 + w_start) send_req(nbfw_pkg::ACT_START, BYTE_W'($urandom));
      else if (r < 3 + w_start + w_end) send_req(nbfw_pkg::ACT_END, BYTE_W'($urandom));
      else send_req(nbfw_pkg::ACT_WRITE, BYTE_W'($urandom_range(255, 0)));
    end
  endtask

  task automatic close_all();
    int n;
    settle();
    n = open_blocks;
    repeat (n) send_req(nbfw_pkg::ACT_END, BYTE_W'($urandom));
  endtask

  // result receiver
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    hold_taken = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !hold_taken) begin
        // hold off long enough for the writer to back up into its input
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(1);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // request stimulus
  initial begin
    items_sent = 0;
    calm[0] = 0;
    calm[1] = 0;
    fast_mode = 1'b0;
    hold_req = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= nbfw_pkg::ACT_WRITE;
    in_ch.data_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray end, unused code, byte extremes, simple and nested blocks
    send_req(nbfw_pkg::ACT_END, 8'h00);
    send_req(ACT_UNUSED, 8'hFF);
    send_req(nbfw_pkg::ACT_WRITE, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'hFF);
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'h5A);
    send_req(nbfw_pkg::ACT_END, 8'h00);
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'hA5);
    send_req(nbfw_pkg::ACT_END, 8'h00);
    send_req(nbfw_pkg::ACT_END, 8'h00);

    // tight buffer: writes and starts run out of room
    settle();
    write_cfg(fill_level + 6);
    run_mix(50, 20, 20);

    // zero capacity: only ends of open blocks still write
    write_cfg(0);
    run_mix(20, 20, 30);
    close_all();

    // size beyond the address space, deep nesting, long output stall
    write_cfg(131071);
    run_mix(60, 70, 10);
    hold_req = 1'b1;
    run_mix(120, 20, 20);
    close_all();
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'h11);
    send_req(nbfw_pkg::ACT_START, 8'h00);

    // capacity lowered below the fill position
    settle();
    write_cfg(fill_level - 1);
    run_mix(40, 15, 30);
    close_all();

    // full rate at the capacity edge: exact fits, then buffer full
    settle();
    write_cfg(fill_level + 9);
    fast_mode = 1'b1;
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'h01);
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'h02);
    send_req(nbfw_pkg::ACT_START, 8'h00);
    send_req(nbfw_pkg::ACT_END, 8'h00);
    send_req(nbfw_pkg::ACT_WRITE, 8'hEE);
    send_req(nbfw_pkg::ACT_END, 8'h00);
    send_req(nbfw_pkg::ACT_END, 8'h00);
    fast_mode = 1'b0;
    close_all();

    settle();
    $display("Sent %0d requests, checked %0d results over buffer sizes 0 to 131071,",
             items_sent, results_seen);
    $display("including a full block stack, a long output stall and exact capacity fits.");
    if (err_count == 0 && pending == 0) begin
      $display("[nested_block_frame_writer_unit] OK");
    end else begin
      $display("[nested_block_frame_writer_unit] ERROR");
    end
    $finish;
  end

endmodule
